@@ rtl/scfla_pkg.sv @@
// Shared constants and codes for the size-class free-list allocator.
`default_nettype none
package scfla_pkg;

    localparam int MAX_IDS_DEF     = 4096;
    localparam int MAX_CLASSES_DEF = 16;

    localparam int OP_W     = 2;
    localparam int REQ_W    = 14;
    localparam int BID_W    = 12;
    localparam int GID_W    = 12;
    localparam int STATUS_W = 3;
    localparam int NODE_W   = 13;
    localparam int DEPTH_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;
    // unused op code: no effect, answers ok
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_DEPTH = 1'd1;

    localparam logic [NODE_W-1:0]  NODE_COUNT_RST   = 13'd4096;
    localparam logic [DEPTH_W-1:0] SEARCH_DEPTH_RST = 5'd3;

    // Size of the catch-all class, also the level stop threshold.
    localparam int SMALL_SIZE = 8;

endpackage
`default_nettype wire

@@ rtl/scfla_store.sv @@
// Id store and id-to-class map: two synchronous memories with registered reads.
`default_nettype none
module scfla_store #(
    parameter int MAX_IDS     = scfla_pkg::MAX_IDS_DEF,
    parameter int MAX_CLASSES = scfla_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_stk_we,
    input  wire logic [$clog2(MAX_IDS)-1:0]     i_stk_waddr,
    input  wire logic [$clog2(MAX_IDS)-1:0]     i_stk_wdata,
    input  wire logic [$clog2(MAX_IDS)-1:0]     i_stk_raddr,
    output logic      [$clog2(MAX_IDS)-1:0]     o_stk_rdata,
    input  wire logic                           i_cls_we,
    input  wire logic [$clog2(MAX_IDS)-1:0]     i_cls_waddr,
    input  wire logic [$clog2(MAX_CLASSES)-1:0] i_cls_wdata,
    input  wire logic [$clog2(MAX_IDS)-1:0]     i_cls_raddr,
    output logic      [$clog2(MAX_CLASSES)-1:0] o_cls_rdata
);
    localparam int IW = $clog2(MAX_IDS);
    localparam int CW = $clog2(MAX_CLASSES);

    logic [IW-1:0] r_stk_mem [MAX_IDS];
    logic [CW-1:0] r_cls_mem [MAX_IDS];

    always_ff @(posedge i_clk) begin
        if (i_stk_we) begin
            r_stk_mem[i_stk_waddr] <= i_stk_wdata;
        end
        o_stk_rdata <= r_stk_mem[i_stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cls_we) begin
            r_cls_mem[i_cls_waddr] <= i_cls_wdata;
        end
        o_cls_rdata <= r_cls_mem[i_cls_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/size_class_free_list_allocator.sv @@
// Top level of the size-class free-list allocator for buffer ids.
//
// Requests arrive on the input channel (i_in_valid / o_in_stall) carrying an
// op: allocate, release, or rebuild. Every request gives exactly one result on
// the output channel (o_out_valid / i_out_stall): a granted id and a status.
// Registers node_count and search_depth are written over the config channel
// (i_cfg_valid / o_cfg_ready, always ready); the user must write them only
// while the block is idle, which the block itself does not enforce.
// One request is processed at a time. What each op does:
//   allocate: the scan walks the class records one per cycle, then one
//             id-store read.
//   release:  one read of the id-to-class memory, then the push; an id out
//             of range is answered from the range check alone.
//   rebuild:  one id is written into each memory per cycle while a class is stacked.
// The finished result sits in an output register, so a new request is taken
// while the previous result is still stalled; the block then waits in its
// result state until the output register frees up.
// Reset clears all class records: allocate answers "too large" and release
// answers "out of range" until the first rebuild. The id memories are not
// cleared; rebuild fills every entry that can later be read.
`default_nettype none
module size_class_free_list_allocator #(
    parameter int MAX_IDS     = scfla_pkg::MAX_IDS_DEF,
    parameter int MAX_CLASSES = scfla_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [scfla_pkg::OP_W-1:0]         i_op,
    input  wire logic [scfla_pkg::REQ_W-1:0]        i_request_size,
    input  wire logic [scfla_pkg::BID_W-1:0]        i_buffer_id,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [scfla_pkg::GID_W-1:0]        o_granted_id,
    output logic      [scfla_pkg::STATUS_W-1:0]     o_status,
    // config write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [scfla_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [scfla_pkg::NODE_W-1:0]       i_cfg_data
);
    localparam int IW   = $clog2(MAX_IDS);
    localparam int CNTW = IW + 1;
    localparam int CW   = $clog2(MAX_CLASSES);
    localparam int TW   = $clog2(MAX_CLASSES + 1);
    localparam int SW   = CNTW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LVL  = 4'd1;  // count levels
    localparam logic [3:0] S_CLS  = 4'd2;  // write one class record
    localparam logic [3:0] S_FILL = 4'd3;  // stack one id of the class
    localparam logic [3:0] S_FIND = 4'd4;  // allocate scan
    localparam logic [3:0] S_POP  = 4'd5;  // id-store read returns
    localparam logic [3:0] S_REL  = 4'd6;  // release range check
    localparam logic [3:0] S_RCHK = 4'd7;  // class of the id returns
    localparam logic [3:0] S_DONE = 4'd8;  // hand result to output register

    // config registers
    logic [scfla_pkg::NODE_W-1:0]  r_node_count;
    logic [scfla_pkg::DEPTH_W-1:0] r_search_depth;

    // class records
    logic [SW-1:0]   r_size [MAX_CLASSES];
    logic [IW-1:0]   r_base [MAX_CLASSES];
    logic [CNTW-1:0] r_cap  [MAX_CLASSES];
    logic [CNTW-1:0] r_fill [MAX_CLASSES];
    logic [TW-1:0]   r_total;
    logic [CNTW-1:0] r_laid;

    // sequencer
    logic [3:0]                    r_state, n_state;
    logic [CNTW-1:0]               r_n, n_n;
    logic [CW-1:0]                 r_k, n_k;
    logic [CW-1:0]                 r_c, n_c;
    logic [CNTW-1:0]               r_id, n_id;
    logic [CNTW-1:0]               r_hi, n_hi;
    logic [CNTW-1:0]               r_pos, n_pos;
    logic [TW-1:0]                 r_s, n_s;
    logic [scfla_pkg::DEPTH_W-1:0] r_tries, n_tries;
    logic                          r_found, n_found;
    logic [scfla_pkg::REQ_W-1:0]   r_req, n_req;
    logic [scfla_pkg::BID_W-1:0]   r_bid, n_bid;
    logic [IW-1:0]                 r_res_id, n_res_id;
    logic [scfla_pkg::STATUS_W-1:0] r_res_st, n_res_st;
    logic                          r_out_valid, n_out_valid;
    logic [scfla_pkg::GID_W-1:0]   r_out_id, n_out_id;
    logic [scfla_pkg::STATUS_W-1:0] r_out_st, n_out_st;

    // record updates
    logic            rec_clr, rec_we, fill_dec, fill_inc;
    logic [CW-1:0]   rec_idx;
    logic [SW-1:0]   rec_size;
    logic [CNTW-1:0] rec_cap;

    // memory ports
    logic          stk_we, cls_we;
    logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic [IW-1:0] cls_waddr, cls_raddr;
    logic [CW-1:0] cls_wdata, cls_rdata;

    // rebuild level math
    logic [CW-1:0]   lvl;
    logic [CNTW-1:0] lvl_lo, lvl_hi;
    logic [SW-1:0]   lvl_size;
    logic            in_acc, out_acc, out_free;
    logic [CW-1:0]   s_idx;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign s_idx    = r_s[CW-1:0];

    // class c holds level nl - c; the last level is the catch-all class
    always_comb begin
        lvl    = r_k - r_c;
        lvl_lo = (lvl == '0) ? '0 : (CNTW'(1) << (lvl - CW'(1))) + CNTW'(1);
        if (r_c == '0) begin
            lvl_hi   = r_n;
            lvl_size = SW'(scfla_pkg::SMALL_SIZE);
        end else begin
            lvl_hi   = (CNTW'(1) << lvl) + CNTW'(1);
            lvl_size = SW'(r_n >> lvl) << 1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_c         = r_c;
        n_id        = r_id;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_s         = r_s;
        n_tries     = r_tries;
        n_found     = r_found;
        n_req       = r_req;
        n_bid       = r_bid;
        n_res_id    = r_res_id;
        n_res_st    = r_res_st;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_out_id    = r_out_id;
        n_out_st    = r_out_st;
        rec_clr     = 1'b0;
        rec_we      = 1'b0;
        fill_dec    = 1'b0;
        fill_inc    = 1'b0;
        rec_idx     = r_c;
        rec_size    = lvl_size;
        rec_cap     = lvl_hi - lvl_lo;
        stk_we      = 1'b0;
        cls_we      = 1'b0;
        stk_waddr   = r_pos[IW-1:0];
        stk_wdata   = r_id[IW-1:0];
        cls_waddr   = r_id[IW-1:0];
        cls_wdata   = r_c;
        stk_raddr   = r_base[s_idx] + r_fill[s_idx][IW-1:0] - IW'(1);
        cls_raddr   = IW'(r_bid);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req    = i_request_size;
                    n_bid    = i_buffer_id;
                    n_res_id = '0;
                    n_res_st = scfla_pkg::ST_OK;
                    case (i_op)
                        scfla_pkg::OP_ALLOC: begin
                            n_s     = '0;
                            n_found = 1'b0;
                            n_state = S_FIND;
                        end
                        scfla_pkg::OP_RELEASE: begin
                            n_state = S_REL;
                        end
                        scfla_pkg::OP_REBUILD: begin
                            rec_clr = 1'b1;
                            n_n     = (32'(r_node_count) > 32'(MAX_IDS)) ?
                                      CNTW'(MAX_IDS) : CNTW'(r_node_count);
                            n_k     = '0;
                            n_state = S_LVL;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LVL: begin
                if (r_k < CW'(MAX_CLASSES - 1) &&
                    32'(r_n >> r_k) > 32'(scfla_pkg::SMALL_SIZE)) begin
                    n_k = r_k + CW'(1);
                end else begin
                    n_c     = '0;
                    n_pos   = '0;
                    n_state = S_CLS;
                end
            end
            S_CLS: begin
                rec_we = 1'b1;
                n_id   = lvl_lo;
                n_hi   = lvl_hi;
                if (lvl_lo < lvl_hi) begin
                    n_state = S_FILL;
                end else if (r_c == r_k) begin
                    n_state = S_DONE;
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            S_FILL: begin
                stk_we = 1'b1;
                cls_we = 1'b1;
                n_pos  = r_pos + CNTW'(1);
                n_id   = r_id + CNTW'(1);
                if (r_id + CNTW'(1) == r_hi) begin
                    if (r_c == r_k) begin
                        n_state = S_DONE;
                    end else begin
                        n_c     = r_c + CW'(1);
                        n_state = S_CLS;
                    end
                end
            end
            S_FIND: begin
                if (!r_found) begin
                    // first class whose size fits the request
                    if (r_s >= r_total) begin
                        n_res_st = scfla_pkg::ST_TOO_LARGE;
                        n_state  = S_DONE;
                    end else if (32'(r_req) > 32'(r_size[s_idx])) begin
                        n_s = r_s + TW'(1);
                    end else begin
                        n_found = 1'b1;
                        n_tries = '0;
                    end
                end else if (r_tries < r_search_depth && r_s < r_total) begin
                    if (r_fill[s_idx] != '0) begin
                        fill_dec = 1'b1;
                        n_state  = S_POP;
                    end else begin
                        n_s     = r_s + TW'(1);
                        n_tries = r_tries + scfla_pkg::DEPTH_W'(1);
                    end
                end else begin
                    n_res_st = scfla_pkg::ST_EMPTY;
                    n_state  = S_DONE;
                end
            end
            S_POP: begin
                n_res_id = stk_rdata;
                n_state  = S_DONE;
            end
            S_REL: begin
                if (32'(r_bid) >= 32'(MAX_IDS) || 32'(r_bid) >= 32'(r_laid)) begin
                    n_res_st = scfla_pkg::ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                rec_idx   = cls_rdata;
                stk_waddr = r_base[cls_rdata] + r_fill[cls_rdata][IW-1:0];
                stk_wdata = IW'(r_bid);
                if (r_fill[cls_rdata] >= r_cap[cls_rdata]) begin
                    n_res_st = scfla_pkg::ST_FULL;
                end else begin
                    stk_we   = 1'b1;
                    fill_inc = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = scfla_pkg::GID_W'(r_res_id);
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_node_count   <= scfla_pkg::NODE_COUNT_RST;
            r_search_depth <= scfla_pkg::SEARCH_DEPTH_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    scfla_pkg::CFG_NODE_COUNT:   r_node_count   <= i_cfg_data;
                    scfla_pkg::CFG_SEARCH_DEPTH: r_search_depth <=
                        i_cfg_data[scfla_pkg::DEPTH_W-1:0];
                    default: ;
                endcase
            end
        end
        r_n      <= n_n;
        r_k      <= n_k;
        r_c      <= n_c;
        r_id     <= n_id;
        r_hi     <= n_hi;
        r_pos    <= n_pos;
        r_s      <= n_s;
        r_tries  <= n_tries;
        r_found  <= n_found;
        r_req    <= n_req;
        r_bid    <= n_bid;
        r_res_id <= n_res_id;
        r_res_st <= n_res_st;
        r_out_id <= n_out_id;
        r_out_st <= n_out_st;
    end

    // class records: cleared at reset and at rebuild start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || rec_clr) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_size[i] <= '0;
                r_base[i] <= '0;
                r_cap[i]  <= '0;
                r_fill[i] <= '0;
            end
            r_total <= '0;
            r_laid  <= '0;
        end else begin
            if (rec_we) begin
                r_size[rec_idx] <= rec_size;
                r_base[rec_idx] <= r_pos[IW-1:0];
                r_cap[rec_idx]  <= rec_cap;
                r_fill[rec_idx] <= rec_cap;
                // layout totals settle with the first record
                r_total         <= TW'(r_k) + TW'(1);
                r_laid          <= r_n;
            end
            if (fill_dec) begin
                r_fill[s_idx] <= r_fill[s_idx] - CNTW'(1);
            end
            if (fill_inc) begin
                r_fill[rec_idx] <= r_fill[rec_idx] + CNTW'(1);
            end
        end
    end

    scfla_store #(
        .MAX_IDS     (MAX_IDS),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_store (
        .i_clk       (i_clk),
        .i_stk_we    (stk_we),
        .i_stk_waddr (stk_waddr),
        .i_stk_wdata (stk_wdata),
        .i_stk_raddr (stk_raddr),
        .o_stk_rdata (stk_rdata),
        .i_cls_we    (cls_we),
        .i_cls_waddr (cls_waddr),
        .i_cls_wdata (cls_wdata),
        .i_cls_raddr (cls_raddr),
        .o_cls_rdata (cls_rdata)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_granted_id = r_out_id;
    assign o_status     = r_out_st;
    assign o_cfg_ready  = 1'b1;

`ifndef ASSERT_OFF
    a_id_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != scfla_pkg::ST_OK) |-> (o_granted_id == '0))
        else $error("granted id set on a failed request");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request accepted while another is in flight");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(MAX_CLASSES))
        else $error("class count beyond table depth");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_inc |-> (r_fill[rec_idx] < r_cap[rec_idx]))
        else $error("push into a full class");
`endif

endmodule
`default_nettype wire

@@ bench/tb_size_class_free_list_allocator.sv @@
// Self-checking testbench for the size-class free-list allocator.
`default_nettype none
module tb_size_class_free_list_allocator;

    localparam int N_IDS     = scfla_pkg::MAX_IDS_DEF;
    localparam int N_CLS     = scfla_pkg::MAX_CLASSES_DEF;
    localparam int SETTLE    = 8;
    localparam int OP_W      = scfla_pkg::OP_W;
    localparam int REQ_W     = scfla_pkg::REQ_W;
    localparam int BID_W     = scfla_pkg::BID_W;
    localparam int GID_W     = scfla_pkg::GID_W;
    localparam int STATUS_W  = scfla_pkg::STATUS_W;
    localparam int NODE_W    = scfla_pkg::NODE_W;
    localparam int DEPTH_W   = scfla_pkg::DEPTH_W;
    localparam int CFG_IDX_W = scfla_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [GID_W-1:0]    gid;
        logic [STATUS_W-1:0] st;
    } t_alloc_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [OP_W-1:0]  i_op;
    logic [REQ_W-1:0] i_request_size;
    logic [BID_W-1:0] i_buffer_id;
    logic o_out_valid;
    logic i_out_stall;
    logic [GID_W-1:0]    o_granted_id;
    logic [STATUS_W-1:0] o_status;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [NODE_W-1:0]    i_cfg_data;

    size_class_free_list_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_request_size(i_request_size), .i_buffer_id(i_buffer_id),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_granted_id(o_granted_id), .o_status(o_status),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow allocator: registers, class records and id stores.
    // ---------------------------------------------------------------
    logic [NODE_W-1:0]  sh_node_count;
    logic [DEPTH_W-1:0] sh_depth;
    logic [REQ_W-1:0]   sh_size  [N_CLS];
    logic [BID_W-1:0]   sh_base  [N_CLS];
    logic [NODE_W-1:0]  sh_cap   [N_CLS];
    logic [NODE_W-1:0]  sh_fill  [N_CLS];
    int                 sh_classes;
    logic [BID_W-1:0]   sh_stack [N_IDS];
    logic [3:0]         sh_owner [N_IDS];

    t_alloc_result pending_results[$];
    int            held_ids[$];      // ids granted and not yet given back
    int            errors = 0;
    int            mismatches = 0;
    int            results_seen = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            n_alloc_ok = 0, n_rebuilds = 0;

    // Lay the classes out from the shadow node count.
    task automatic shadow_rebuild();
        int lvl_size[N_CLS];
        int lvl_lo[N_CLS];
        int lvl_hi[N_CLS];
        int n, nl, d, lo, pos, lv;
        n   = (sh_node_count > N_IDS) ? N_IDS : int'(sh_node_count);
        nl  = 0;
        d   = 1;
        lo  = 0;
        pos = 0;
        while (nl < N_CLS - 1 && n / d > scfla_pkg::SMALL_SIZE) begin
            lvl_size[nl] = (n / d) * 2;
            lvl_lo[nl]   = lo;
            lvl_hi[nl]   = d + 1;
            nl++;
            lo = d + 1;
            d  = d * 2;
        end
        lvl_size[nl] = scfla_pkg::SMALL_SIZE;
        lvl_lo[nl]   = lo;
        lvl_hi[nl]   = (lo < n) ? n : lo;
        sh_classes   = nl + 1;
        // smallest size goes to class 0
        for (int c = 0; c < N_CLS; c++) begin
            if (c < sh_classes) begin
                lv = sh_classes - 1 - c;
                sh_size[c] = REQ_W'(lvl_size[lv]);
                sh_base[c] = pos[BID_W-1:0];
                sh_cap[c]  = NODE_W'(lvl_hi[lv] - lvl_lo[lv]);
                sh_fill[c] = sh_cap[c];
                for (int id = lvl_lo[lv]; id < lvl_hi[lv]; id++) begin
                    sh_stack[pos % N_IDS] = id[BID_W-1:0];
                    sh_owner[id % N_IDS]  = c[3:0];
                    pos++;
                end
            end else begin
                sh_size[c] = '0;
                sh_base[c] = '0;
                sh_cap[c]  = '0;
                sh_fill[c] = '0;
            end
        end
    endtask

    // Work out the result of one request and advance the shadow state.
    task automatic predict_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                                   input logic [BID_W-1:0] bid, output t_alloc_result res);
        int f, s, tries, total, c;
        res.gid = '0;
        res.st  = scfla_pkg::ST_OK;
        if (op == scfla_pkg::OP_ALLOC) begin
            f = 0;
            while (f < sh_classes && req > sh_size[f]) f++;
            if (f >= sh_classes) begin
                res.st = scfla_pkg::ST_TOO_LARGE;
            end else begin
                res.st = scfla_pkg::ST_EMPTY;
                s = f;
                tries = 0;
                while (tries < sh_depth && s < sh_classes) begin
                    if (sh_fill[s] > 0) begin
                        sh_fill[s] = sh_fill[s] - NODE_W'(1);
                        res.gid = sh_stack[(int'(sh_base[s]) + int'(sh_fill[s])) % N_IDS];
                        res.st  = scfla_pkg::ST_OK;
                        break;
                    end
                    s++;
                    tries++;
                end
            end
        end else if (op == scfla_pkg::OP_RELEASE) begin
            total = 0;
            for (int k = 0; k < sh_classes; k++) total += sh_cap[k];
            if (bid >= total) begin
                res.st = scfla_pkg::ST_RANGE;
            end else begin
                c = sh_owner[bid];
                if (sh_fill[c] >= sh_cap[c]) begin
                    res.st = scfla_pkg::ST_FULL;
                end else begin
                    sh_stack[(int'(sh_base[c]) + int'(sh_fill[c])) % N_IDS] = bid;
                    sh_fill[c] = sh_fill[c] + NODE_W'(1);
                end
            end
        end else if (op == scfla_pkg::OP_REBUILD) begin
            shadow_rebuild();
        end
    endtask

    // ---------------------------------------------------------------
    // Request driver. Called right after a rising edge; leaves valid high
    // so back-to-back requests never lower and raise it in one step.
    // ---------------------------------------------------------------
    task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                                input logic [BID_W-1:0] bid);
        t_alloc_result res;
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 6) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_request_size <= req;
        i_buffer_id    <= bid;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(op, req, bid, res);
        pending_results.insert(pending_results.size(), res);
        if (op == scfla_pkg::OP_ALLOC && res.st == scfla_pkg::ST_OK) begin
            held_ids.insert(held_ids.size(), int'(res.gid));
            n_alloc_ok++;
        end
        if (op == scfla_pkg::OP_REBUILD) begin
            held_ids.delete();
            n_rebuilds++;
        end
    endtask

    // Drop valid and hold until every result is back, then settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write, only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NODE_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == scfla_pkg::CFG_NODE_COUNT) sh_node_count = data;
        else                                  sh_depth      = data[DEPTH_W-1:0];
    endtask

    task automatic relayout(input int nodes, input int depth);
        write_reg(scfla_pkg::CFG_NODE_COUNT, nodes[NODE_W-1:0]);
        write_reg(scfla_pkg::CFG_SEARCH_DEPTH, depth[NODE_W-1:0]);
        send_request(scfla_pkg::OP_REBUILD, REQ_W'($urandom()), BID_W'($urandom()));
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall, and compare each accepted result.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected result: id=%0d status=%0d",
                                 o_granted_id, o_status);
                    mismatches++;
                end else begin
                    if (o_granted_id !== pending_results[0].gid ||
                        o_status !== pending_results[0].st) begin
                        errors++;
                        if (mismatches < 10)
                            $display({"mismatch #%0d: expected id=%0d status=%0d, ",
                                      "got id=%0d status=%0d"},
                                     results_seen, pending_results[0].gid,
                                     pending_results[0].st, o_granted_id, o_status);
                        mismatches++;
                    end
                    void'(pending_results.pop_front());
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Before any layout: allocate is too large, release is out of range, the unused op answers ok.
    task automatic test_no_layout();
        send_request(scfla_pkg::OP_ALLOC, '0, '0);
        send_request(scfla_pkg::OP_ALLOC, 14'h3FFF, '0);
        send_request(scfla_pkg::OP_RELEASE, '0, '0);
        send_request(scfla_pkg::OP_RELEASE, '0, 12'hFFF);
        send_request(scfla_pkg::OP_NONE, 14'h3FFF, 12'hFFF);
    endtask

    // Tiny layouts: node count zero, one, just above the level threshold.
    task automatic test_tiny_layouts();
        relayout(0, 3);
        send_request(scfla_pkg::OP_ALLOC, 14'd8, '0);
        send_request(scfla_pkg::OP_RELEASE, '0, '0);
        relayout(1, 1);
        send_request(scfla_pkg::OP_ALLOC, 14'd0, '0);
        send_request(scfla_pkg::OP_ALLOC, 14'd1, '0);      // class now empty
        send_request(scfla_pkg::OP_RELEASE, '0, '0);
        send_request(scfla_pkg::OP_RELEASE, '0, '0);       // class full
        send_request(scfla_pkg::OP_ALLOC, 14'd9, '0);      // larger than every class
        relayout(17, 3);
        send_request(scfla_pkg::OP_ALLOC, 14'd34, '0);
        send_request(scfla_pkg::OP_ALLOC, 14'd34, '0);
        send_request(scfla_pkg::OP_ALLOC, 14'd34, '0);     // search runs past the last class
        send_request(scfla_pkg::OP_RELEASE, '0, 12'd17);   // just outside the layout
    endtask

    // Extreme register values: depth zero and maximum, node count over the id range.
    task automatic test_register_extremes();
        relayout(8191, 0);
        send_request(scfla_pkg::OP_ALLOC, 14'd1, '0);
        write_reg(scfla_pkg::CFG_SEARCH_DEPTH, 13'h1F);
        send_request(scfla_pkg::OP_ALLOC, 14'd8192, '0);
        send_request(scfla_pkg::OP_ALLOC, 14'd0, '0);
        send_request(scfla_pkg::OP_RELEASE, '0, 12'hFFF);
        relayout(4096, 16);
        send_request(scfla_pkg::OP_ALLOC, 14'd1, '0);
        send_request(scfla_pkg::OP_RELEASE, '0, 12'd4095);
    endtask

    task automatic random_request();
        int r, c, sz, idx;
        r = $urandom_range(0, 99);
        if (r < 48) begin
            if (sh_classes > 0 && $urandom_range(0, 99) < 80) begin
                c  = $urandom_range(0, sh_classes - 1);
                sz = int'(sh_size[c]) + $urandom_range(0, 2) - 1;
                if (sz < 0) sz = 0;
            end else begin
                sz = $urandom_range(0, 16383);
            end
            send_request(scfla_pkg::OP_ALLOC, sz[REQ_W-1:0], BID_W'($urandom()));
        end else if (r < 92) begin
            if (held_ids.size() > 0 && $urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, held_ids.size() - 1);
                send_request(scfla_pkg::OP_RELEASE, REQ_W'($urandom()),
                             held_ids[idx][BID_W-1:0]);
                held_ids.delete(idx);
            end else begin
                send_request(scfla_pkg::OP_RELEASE, REQ_W'($urandom()),
                             BID_W'($urandom()));
            end
        end else if (r < 95) begin
            send_request(scfla_pkg::OP_REBUILD, REQ_W'($urandom()), BID_W'($urandom()));
        end else begin
            send_request(scfla_pkg::OP_NONE, REQ_W'($urandom()), BID_W'($urandom()));
        end
    endtask

    // Random traffic in chunks, each chunk on a fresh small layout.
    task automatic test_random_traffic(input int items);
        for (int k = 0; k < items; k++) begin
            if (k % 45 == 0)
                relayout($urandom_range(1, 300), $urandom_range(1, 16));
            if (k == items / 2)
                drain_results();   // hold off until the block has caught up
            random_request();
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= '0;
        i_request_size <= '0;
        i_buffer_id    <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        sh_node_count  = scfla_pkg::NODE_COUNT_RST;
        sh_depth       = scfla_pkg::SEARCH_DEPTH_RST;
        sh_classes     = 0;
        for (int c = 0; c < N_CLS; c++) begin
            sh_size[c] = '0;
            sh_base[c] = '0;
            sh_cap[c]  = '0;
            sh_fill[c] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 33;
        recv_stall_pct = 57;
        test_no_layout();
        test_tiny_layouts();
        test_register_extremes();
        test_random_traffic(180);
        send_idle_pct  = 57;
        recv_stall_pct = 33;
        test_random_traffic(180);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(180);
        relayout(4096, 3);
        drain_results();

        if (pending_results.size() != 0) errors++;
        $display("Covered %0d results, %0d successful allocations, %0d rebuilds,",
                 results_seen, n_alloc_ok, n_rebuilds);
        $display("with empty, tiny, full-size layouts and search depths from 0 to 31.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
